// ----- rtl/abpf_pkg.sv -----
// ----------------------------------------------------------------------------
// abpf_pkg
// Shared types, constants and helpers of the position and velocity fusion
// core.
// ----------------------------------------------------------------------------
package abpf_pkg;

	typedef logic signed [47:0] pos_t;
	typedef logic signed [63:0] wide_t;
	typedef logic [23:0]        coef_t;

	// Event tags carried by the command field.
	typedef enum logic [1:0] {
		CMD_ACCEL = 2'd0,
		CMD_BARO  = 2'd1,
		CMD_FLOW  = 2'd2,
		CMD_MODE  = 2'd3
	} cmd_t;

	// Configuration register indexes (byte address is four times the index).
	typedef enum logic [2:0] {
		REG_POS_XY_CORR  = 3'd0,
		REG_POS_Z_CORR   = 3'd1,
		REG_VEL_XY_INTEG = 3'd2,
		REG_VEL_Z_INTEG  = 3'd3,
		REG_BARO_FAST    = 3'd4,
		REG_BARO_SLOW    = 3'd5,
		REG_AZ_LIMIT     = 3'd6,
		REG_FLOW_SCALE   = 3'd7
	} reg_idx_t;

	localparam int PADDR_W = 5;

	localparam coef_t       RST_POS_XY_CORR  = 24'd671089;
	localparam coef_t       RST_POS_Z_CORR   = 24'd671089;
	localparam coef_t       RST_VEL_XY_INTEG = 24'd1678;
	localparam coef_t       RST_VEL_Z_INTEG  = 24'd33554;
	localparam coef_t       RST_BARO_FAST    = 24'd838861;
	localparam coef_t       RST_BARO_SLOW    = 24'd83886;
	localparam logic [14:0] RST_AZ_LIMIT     = 15'd300;
	localparam coef_t       RST_FLOW_SCALE   = 24'd335544;

	// Flow sensor orientation codes and the mode code that selects flow height.
	localparam logic [7:0] DIR_DOWN = 8'd0;
	localparam logic [7:0] DIR_UP   = 8'd1;
	localparam logic [7:0] MODE_FLOW_HEIGHT = 8'd0;

	// State memory layout: one 48-bit word per entry.
	localparam int RAM_DEPTH = 20;
	localparam int RAM_AW    = 5;
	localparam logic [RAM_AW-1:0] A_VEL   = 5'd0;
	localparam logic [RAM_AW-1:0] A_IP    = 5'd3;
	localparam logic [RAM_AW-1:0] A_IPP   = 5'd6;
	localparam logic [RAM_AW-1:0] A_FP    = 5'd9;
	localparam logic [RAM_AW-1:0] A_REF   = 5'd12;
	localparam logic [RAM_AW-1:0] A_LF    = 5'd15;
	localparam logic [RAM_AW-1:0] A_BARO  = 5'd18;
	localparam logic [RAM_AW-1:0] A_HPREV = 5'd19;

	// Arithmetic unit widths.
	localparam int MUL_D_W   = 50;
	localparam int MUL_R_W   = 52;
	localparam int DIV_N_W   = 51;
	localparam int DIV_U_W   = 52;
	localparam int DIV_Q_W   = 53;
	localparam int DIV_RADIX_BITS = 4;
	localparam int DIV_STEPS = DIV_U_W / DIV_RADIX_BITS;
	localparam int ACCEL_FREQ = 500;
	localparam int HALF_FREQ  = ACCEL_FREQ / 2;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_A_VRD, ST_A_VWAIT, ST_A_IPMUL, ST_A_RFRD, ST_A_IPDIV, ST_A_IPWAIT,
		ST_A_VO, ST_A_FPST, ST_A_FPWAIT, ST_A_OUT,
		ST_B_RD, ST_B_MUL, ST_B_WAIT,
		ST_F_MX, ST_F_MXW, ST_F_MYW, ST_F_LZ, ST_F_RD0, ST_F_RD1, ST_F_A0,
		ST_F_RD2, ST_F_A1, ST_F_H,
		ST_H_RD, ST_H_UPD, ST_H_HP
	} st_t;

	// Clamp a wide signed value into the 48-bit Q31.16 range.
	function automatic pos_t sat48(input wide_t v);
		pos_t r;
		if (v[63:47] == {17{v[63]}}) begin
			r = v[47:0];
		end else if (v[63]) begin
			r = {1'b1, {47{1'b0}}};
		end else begin
			r = {1'b0, {47{1'b1}}};
		end
		return r;
	endfunction

endpackage

// ----- rtl/abpf_in_if.sv -----
// ----------------------------------------------------------------------------
// abpf_in_if
// Input event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
interface abpf_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [31:0] sample_x;
	logic signed [31:0] sample_y;
	logic signed [31:0] sample_z;
	logic [7:0]        flow_direction;
	logic [7:0]        mode_value;

	modport source (
		output valid, command, sample_x, sample_y, sample_z, flow_direction, mode_value,
		input  ready
	);
	modport sink (
		input  valid, command, sample_x, sample_y, sample_z, flow_direction, mode_value,
		output ready
	);
endinterface

// ----- rtl/abpf_out_if.sv -----
// ----------------------------------------------------------------------------
// abpf_out_if
// Result channel: valid/ready handshake with fused position and velocity.
// ----------------------------------------------------------------------------
interface abpf_out_if;
	logic              valid;
	logic              ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic signed [47:0] pos_z;
	logic signed [47:0] vel_x;
	logic signed [47:0] vel_y;
	logic signed [47:0] vel_z;

	modport source (
		output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		output ready
	);
endinterface

// ----- rtl/abpf_mulq24.sv -----
// ----------------------------------------------------------------------------
// abpf_mulq24
// Rounded product of a signed value and an unsigned Q0.24 coefficient,
// computed as two partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module abpf_mulq24 (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [abpf_pkg::MUL_D_W-1:0]  d,
	input  abpf_pkg::coef_t                      c,
	output abpf_pkg::unit_sts_t                  sts,
	output logic signed [abpf_pkg::MUL_R_W-1:0]  res
);

	logic                                busy_q;
	logic                                done_q;
	logic [1:0]                          ph_q;
	logic signed [abpf_pkg::MUL_D_W-1:0] d_q;
	abpf_pkg::coef_t                     c_q;
	logic signed [50:0]                  phi_q;
	logic [47:0]                         plo_q;
	logic signed [abpf_pkg::MUL_R_W-1:0] res_q;

	logic signed [25:0] ma;
	logic signed [24:0] mb;
	logic signed [50:0] prod;
	logic [48:0]        rnd;

	// Phase 0 takes the high part (floor of d over 2^24), phase 1 the low part.
	always_comb begin
		ma   = (ph_q == 2'd0) ? d_q[49:24] : $signed({2'b00, d_q[23:0]});
		mb   = $signed({1'b0, c_q});
		prod = 51'(ma) * 51'(mb);
		rnd  = {1'b0, plo_q} + 49'd8388608;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 2'd0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d;
			c_q <= c;
		end else if (busy_q) begin
			case (ph_q)
				2'd0:    phi_q <= prod;
				2'd1:    plo_q <= prod[47:0];
				default: res_q <= 52'(phi_q) + $signed({27'd0, rnd[48:24]});
			endcase
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = res_q;

endmodule

// ----- rtl/abpf_div500.sv -----
// ----------------------------------------------------------------------------
// abpf_div500
// Floor division of a signed value by 500, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module abpf_div500 (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [abpf_pkg::DIV_N_W-1:0]  n,
	output abpf_pkg::unit_sts_t                  sts,
	output logic signed [abpf_pkg::DIV_Q_W-1:0]  q
);

	localparam int CNT_W = $clog2(abpf_pkg::DIV_STEPS);
	localparam int RB    = abpf_pkg::DIV_RADIX_BITS;

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	logic [abpf_pkg::DIV_U_W-1:0] u_q;
	logic [8:0]                  rem_q;

	logic [8:0]    r;
	logic [9:0]    t;
	logic [RB-1:0] qb;

	// Restoring steps on the remainder; negative inputs are divided as
	// (-n - 1) and the quotient complemented, which gives the floor.
	always_comb begin
		r  = rem_q;
		t  = '0;
		qb = '0;
		for (int k = RB - 1; k >= 0; k--) begin
			t = {r, u_q[abpf_pkg::DIV_U_W - RB + k]};
			if (t >= 10'(abpf_pkg::ACCEL_FREQ)) begin
				r     = 9'(t - 10'(abpf_pkg::ACCEL_FREQ));
				qb[k] = 1'b1;
			end else begin
				r = t[8:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(abpf_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= n[abpf_pkg::DIV_N_W-1];
			u_q   <= {2'b00, (n[abpf_pkg::DIV_N_W-1] ? ~n[49:0] : n[49:0])};
			rem_q <= '0;
		end else if (busy_q) begin
			u_q   <= {u_q[abpf_pkg::DIV_U_W-RB-1:0], qb};
			rem_q <= r;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign q = neg_q ? ~$signed({1'b0, u_q}) : $signed({1'b0, u_q});

endmodule

// ----- rtl/accel_baro_flow_position_fusion_core.sv -----
// ----------------------------------------------------------------------------
// accel_baro_flow_position_fusion_core
// Complementary position and velocity filter over accel, baro and flow events.
// ----------------------------------------------------------------------------
// An accel sample runs through, per axis, two divide-by-500 passes and two
// multiplier passes before its result beat.
// One event is processed at a time; the result register lets the next event
// be accepted while a result beat still waits on the output side.
// Reset (arst_n low) zeroes all filter state and loads the register defaults.
// ----------------------------------------------------------------------------
module accel_baro_flow_position_fusion_core (
	input  logic                          clk,
	input  logic                          arst_n,
	abpf_in_if.sink                       samples,
	abpf_out_if.source                    results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abpf_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	abpf_pkg::coef_t pos_xy_corr_q, pos_z_corr_q, vel_xy_integ_q, vel_z_integ_q;
	abpf_pkg::coef_t baro_fast_q, baro_slow_q, flow_scale_q;
	logic [14:0]     az_limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_xy_corr_q  <= abpf_pkg::RST_POS_XY_CORR;
			pos_z_corr_q   <= abpf_pkg::RST_POS_Z_CORR;
			vel_xy_integ_q <= abpf_pkg::RST_VEL_XY_INTEG;
			vel_z_integ_q  <= abpf_pkg::RST_VEL_Z_INTEG;
			baro_fast_q    <= abpf_pkg::RST_BARO_FAST;
			baro_slow_q    <= abpf_pkg::RST_BARO_SLOW;
			az_limit_q     <= abpf_pkg::RST_AZ_LIMIT;
			flow_scale_q   <= abpf_pkg::RST_FLOW_SCALE;
		end else if (psel && penable && pwrite) begin
			unique case (abpf_pkg::reg_idx_t'(paddr[4:2]))
				abpf_pkg::REG_POS_XY_CORR:  pos_xy_corr_q  <= pwdata[23:0];
				abpf_pkg::REG_POS_Z_CORR:   pos_z_corr_q   <= pwdata[23:0];
				abpf_pkg::REG_VEL_XY_INTEG: vel_xy_integ_q <= pwdata[23:0];
				abpf_pkg::REG_VEL_Z_INTEG:  vel_z_integ_q  <= pwdata[23:0];
				abpf_pkg::REG_BARO_FAST:    baro_fast_q    <= pwdata[23:0];
				abpf_pkg::REG_BARO_SLOW:    baro_slow_q    <= pwdata[23:0];
				abpf_pkg::REG_AZ_LIMIT:     az_limit_q     <= pwdata[14:0];
				abpf_pkg::REG_FLOW_SCALE:   flow_scale_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (abpf_pkg::reg_idx_t'(paddr[4:2]))
			abpf_pkg::REG_POS_XY_CORR:  prdata = {8'd0, pos_xy_corr_q};
			abpf_pkg::REG_POS_Z_CORR:   prdata = {8'd0, pos_z_corr_q};
			abpf_pkg::REG_VEL_XY_INTEG: prdata = {8'd0, vel_xy_integ_q};
			abpf_pkg::REG_VEL_Z_INTEG:  prdata = {8'd0, vel_z_integ_q};
			abpf_pkg::REG_BARO_FAST:    prdata = {8'd0, baro_fast_q};
			abpf_pkg::REG_BARO_SLOW:    prdata = {8'd0, baro_slow_q};
			abpf_pkg::REG_AZ_LIMIT:     prdata = {17'd0, az_limit_q};
			abpf_pkg::REG_FLOW_SCALE:   prdata = {8'd0, flow_scale_q};
			default:                    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// State memory. Every vector state word lives here; an entry that has
	// not been written since reset reads as zero through its valid bit.
	// A read of the entry written in the same cycle returns the new data.
	// ------------------------------------------------------------------
	logic                          re, we;
	logic [abpf_pkg::RAM_AW-1:0]   ra, wa;
	abpf_pkg::pos_t                wd;
	abpf_pkg::pos_t                mem_q [abpf_pkg::RAM_DEPTH];
	logic [abpf_pkg::RAM_DEPTH-1:0] valid_q;
	abpf_pkg::pos_t                rd_q;
	logic                          rdv_q;
	abpf_pkg::pos_t                rd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd_q <= (we && wa == ra) ? wd : mem_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
			if (re) begin
				rdv_q <= valid_q[ra] | (we && wa == ra);
			end
		end
	end

	assign rd = rdv_q ? rd_q : '0;

	// ------------------------------------------------------------------
	// Shared arithmetic units
	// ------------------------------------------------------------------
	logic                                mul_start, div_start;
	logic signed [abpf_pkg::MUL_D_W-1:0] mul_d;
	abpf_pkg::coef_t                     mul_c;
	logic signed [abpf_pkg::MUL_R_W-1:0] mul_res;
	logic signed [abpf_pkg::DIV_N_W-1:0] div_n;
	logic signed [abpf_pkg::DIV_Q_W-1:0] div_q;
	abpf_pkg::unit_sts_t                 mul_sts, div_sts;

	abpf_mulq24 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.d      (mul_d),
		.c      (mul_c),
		.sts    (mul_sts),
		.res    (mul_res)
	);

	abpf_div500 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.sts    (div_sts),
		.q      (div_q)
	);

	// ------------------------------------------------------------------
	// Event registers and working registers
	// ------------------------------------------------------------------
	abpf_pkg::st_t      state_q, state_d;
	logic [1:0]         ax_q;
	logic signed [31:0] acc_q [3];
	logic [7:0]         dir_q;
	logic [7:0]         cur_mode_q, prev_mode_q;
	logic signed [15:0] last_az_q;
	abpf_pkg::pos_t     x_q, y_q;
	abpf_pkg::pos_t     fp_q [3];
	abpf_pkg::pos_t     vo_q [3];
	logic               out_valid_q;
	abpf_pkg::pos_t     out_px_q, out_py_q, out_pz_q, out_vx_q, out_vy_q, out_vz_q;

	logic in_acc;
	assign samples.ready = (state_q == abpf_pkg::ST_IDLE);
	assign in_acc = samples.valid && samples.ready;

	// ------------------------------------------------------------------
	// Datapath expressions shared by the sequencer
	// ------------------------------------------------------------------
	abpf_pkg::wide_t acc_w, ref_w, dif_w, sx_w, sy_w;
	abpf_pkg::pos_t  add_rd_x, add_rd_mul, add_x_mul, add_rd_div, add_x_div;
	abpf_pkg::pos_t  vo_w, ht_w, m_sat, m_neg;
	logic [16:0]     az_ext, az_mag;
	logic            fast_sel, reseed, out_take;
	logic [abpf_pkg::RAM_AW-1:0] ax_ext;

	always_comb begin
		ax_ext     = {3'd0, ax_q};
		acc_w      = (abpf_pkg::wide_t'(acc_q[ax_q]) <<< 16)
		           + abpf_pkg::wide_t'(abpf_pkg::HALF_FREQ);
		ref_w      = abpf_pkg::wide_t'(rd) - abpf_pkg::wide_t'(x_q)
		           + abpf_pkg::wide_t'(abpf_pkg::HALF_FREQ);
		dif_w      = abpf_pkg::wide_t'(x_q) - abpf_pkg::wide_t'(rd);
		sx_w       = abpf_pkg::wide_t'(samples_x_q()) <<< 16;
		sy_w       = abpf_pkg::wide_t'(acc_q[1]) <<< 16;
		add_rd_x   = abpf_pkg::sat48(abpf_pkg::wide_t'(rd) + abpf_pkg::wide_t'(x_q));
		add_rd_mul = abpf_pkg::sat48(abpf_pkg::wide_t'(rd) + abpf_pkg::wide_t'(mul_res));
		add_x_mul  = abpf_pkg::sat48(abpf_pkg::wide_t'(x_q) + abpf_pkg::wide_t'(mul_res));
		add_rd_div = abpf_pkg::sat48(abpf_pkg::wide_t'(rd) + abpf_pkg::wide_t'(div_q));
		add_x_div  = abpf_pkg::sat48(abpf_pkg::wide_t'(x_q) + abpf_pkg::wide_t'(div_q));
		// Times 500 as 512 - 8 - 4.
		vo_w       = abpf_pkg::sat48((dif_w <<< 9) - (dif_w <<< 3) - (dif_w <<< 2));
		ht_w       = abpf_pkg::sat48(abpf_pkg::wide_t'(rd)
		           + abpf_pkg::wide_t'(x_q) - abpf_pkg::wide_t'(y_q));
		m_sat      = abpf_pkg::sat48(abpf_pkg::wide_t'(mul_res));
		m_neg      = abpf_pkg::sat48(-abpf_pkg::wide_t'(m_sat));
		az_ext     = {last_az_q[15], last_az_q};
		az_mag     = az_ext[16] ? 17'(-az_ext) : az_ext;
		fast_sel   = az_mag > {2'b00, az_limit_q};
		// The height source just switched between flow range and baro.
		reseed     = (cur_mode_q == abpf_pkg::MODE_FLOW_HEIGHT)
		           != (prev_mode_q == abpf_pkg::MODE_FLOW_HEIGHT);
		out_take   = !out_valid_q || results.ready;
	end

	function automatic logic signed [31:0] samples_x_q();
		return acc_q[0];
	endfunction

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			abpf_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (abpf_pkg::cmd_t'(samples.command))
						abpf_pkg::CMD_ACCEL: state_d = abpf_pkg::ST_A_VRD;
						abpf_pkg::CMD_BARO:  state_d = abpf_pkg::ST_B_RD;
						abpf_pkg::CMD_FLOW: begin
							if (samples.flow_direction == abpf_pkg::DIR_DOWN
							    || samples.flow_direction == abpf_pkg::DIR_UP) begin
								state_d = abpf_pkg::ST_F_MX;
							end else begin
								state_d = abpf_pkg::ST_F_RD0;
							end
						end
						default: state_d = abpf_pkg::ST_IDLE;
					endcase
				end
			end
			abpf_pkg::ST_A_VRD:    state_d = abpf_pkg::ST_A_VWAIT;
			abpf_pkg::ST_A_VWAIT:  if (div_sts.done) state_d = abpf_pkg::ST_A_IPMUL;
			abpf_pkg::ST_A_IPMUL:  if (mul_sts.done) state_d = abpf_pkg::ST_A_RFRD;
			abpf_pkg::ST_A_RFRD:   state_d = abpf_pkg::ST_A_IPDIV;
			abpf_pkg::ST_A_IPDIV:  state_d = abpf_pkg::ST_A_IPWAIT;
			abpf_pkg::ST_A_IPWAIT: if (div_sts.done) state_d = abpf_pkg::ST_A_VO;
			abpf_pkg::ST_A_VO:     state_d = abpf_pkg::ST_A_FPST;
			abpf_pkg::ST_A_FPST:   state_d = abpf_pkg::ST_A_FPWAIT;
			abpf_pkg::ST_A_FPWAIT: begin
				if (mul_sts.done) begin
					state_d = (ax_q == 2'd2) ? abpf_pkg::ST_A_OUT : abpf_pkg::ST_A_VRD;
				end
			end
			abpf_pkg::ST_A_OUT:    if (out_take) state_d = abpf_pkg::ST_IDLE;
			abpf_pkg::ST_B_RD:     state_d = abpf_pkg::ST_B_MUL;
			abpf_pkg::ST_B_MUL:    state_d = abpf_pkg::ST_B_WAIT;
			abpf_pkg::ST_B_WAIT: begin
				if (mul_sts.done) begin
					state_d = (cur_mode_q != abpf_pkg::MODE_FLOW_HEIGHT)
					        ? abpf_pkg::ST_H_RD : abpf_pkg::ST_IDLE;
				end
			end
			abpf_pkg::ST_F_MX:     state_d = abpf_pkg::ST_F_MXW;
			abpf_pkg::ST_F_MXW:    if (mul_sts.done) state_d = abpf_pkg::ST_F_MYW;
			abpf_pkg::ST_F_MYW: begin
				if (mul_sts.done) begin
					state_d = (dir_q == abpf_pkg::DIR_DOWN)
					        ? abpf_pkg::ST_F_LZ : abpf_pkg::ST_F_RD0;
				end
			end
			abpf_pkg::ST_F_LZ:     state_d = abpf_pkg::ST_F_RD0;
			abpf_pkg::ST_F_RD0:    state_d = abpf_pkg::ST_F_RD1;
			abpf_pkg::ST_F_RD1:    state_d = abpf_pkg::ST_F_A0;
			abpf_pkg::ST_F_A0:     state_d = abpf_pkg::ST_F_RD2;
			abpf_pkg::ST_F_RD2:    state_d = abpf_pkg::ST_F_A1;
			abpf_pkg::ST_F_A1: begin
				state_d = (cur_mode_q == abpf_pkg::MODE_FLOW_HEIGHT
				           && dir_q == abpf_pkg::DIR_DOWN)
				        ? abpf_pkg::ST_F_H : abpf_pkg::ST_IDLE;
			end
			abpf_pkg::ST_F_H:      state_d = abpf_pkg::ST_H_RD;
			abpf_pkg::ST_H_RD:     state_d = abpf_pkg::ST_H_UPD;
			abpf_pkg::ST_H_UPD:    state_d = abpf_pkg::ST_H_HP;
			abpf_pkg::ST_H_HP:     state_d = abpf_pkg::ST_IDLE;
			default:               state_d = abpf_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: memory and unit controls
	// ------------------------------------------------------------------
	always_comb begin
		re        = 1'b0;
		ra        = abpf_pkg::A_VEL;
		we        = 1'b0;
		wa        = abpf_pkg::A_VEL;
		wd        = '0;
		mul_start = 1'b0;
		mul_d     = '0;
		mul_c     = '0;
		div_start = 1'b0;
		div_n     = '0;
		unique case (state_q)
			abpf_pkg::ST_A_VRD: begin
				// Velocity gains round(accel * 2^16 / 500).
				re        = 1'b1;
				ra        = abpf_pkg::A_VEL + ax_ext;
				div_start = 1'b1;
				div_n     = $signed(acc_w[abpf_pkg::DIV_N_W-1:0]);
			end
			abpf_pkg::ST_A_VWAIT: begin
				if (div_sts.done) begin
					we        = 1'b1;
					wa        = abpf_pkg::A_VEL + ax_ext;
					wd        = add_rd_div;
					mul_start = 1'b1;
					mul_d     = abpf_pkg::MUL_D_W'(add_rd_div);
					mul_c     = (ax_q == 2'd2) ? vel_z_integ_q : vel_xy_integ_q;
				end
			end
			abpf_pkg::ST_A_IPMUL: begin
				re = 1'b1;
				ra = abpf_pkg::A_IP + ax_ext;
			end
			abpf_pkg::ST_A_RFRD: begin
				re = 1'b1;
				ra = abpf_pkg::A_REF + ax_ext;
			end
			abpf_pkg::ST_A_IPDIV: begin
				// Inertial position is pulled by (reference - inertial) / 500.
				div_start = 1'b1;
				div_n     = $signed(ref_w[abpf_pkg::DIV_N_W-1:0]);
			end
			abpf_pkg::ST_A_IPWAIT: begin
				if (div_sts.done) begin
					we = 1'b1;
					wa = abpf_pkg::A_IP + ax_ext;
					wd = add_x_div;
					re = 1'b1;
					ra = abpf_pkg::A_IPP + ax_ext;
				end
			end
			abpf_pkg::ST_A_VO: begin
				we = 1'b1;
				wa = abpf_pkg::A_IPP + ax_ext;
				wd = x_q;
				re = 1'b1;
				ra = abpf_pkg::A_FP + ax_ext;
			end
			abpf_pkg::ST_A_FPST: begin
				mul_start = 1'b1;
				mul_d     = abpf_pkg::MUL_D_W'(abpf_pkg::wide_t'(y_q) - abpf_pkg::wide_t'(rd));
				mul_c     = (ax_q == 2'd2) ? pos_z_corr_q : pos_xy_corr_q;
			end
			abpf_pkg::ST_A_FPWAIT: begin
				if (mul_sts.done) begin
					we = 1'b1;
					wa = abpf_pkg::A_FP + ax_ext;
					wd = add_x_mul;
				end
			end
			abpf_pkg::ST_B_RD: begin
				re = 1'b1;
				ra = abpf_pkg::A_BARO;
			end
			abpf_pkg::ST_B_MUL: begin
				mul_start = 1'b1;
				mul_d     = abpf_pkg::MUL_D_W'(abpf_pkg::wide_t'(acc_q[0])
				          - abpf_pkg::wide_t'(rd));
				mul_c     = fast_sel ? baro_fast_q : baro_slow_q;
			end
			abpf_pkg::ST_B_WAIT: begin
				if (mul_sts.done) begin
					we = 1'b1;
					wa = abpf_pkg::A_BARO;
					wd = add_x_mul;
					re = 1'b1;
					ra = abpf_pkg::A_HPREV;
				end
			end
			abpf_pkg::ST_F_MX: begin
				// round(dx * scale / 2^8) is the Q0.24 product of dx * 2^16.
				mul_start = 1'b1;
				mul_d     = $signed(sx_w[abpf_pkg::MUL_D_W-1:0]);
				mul_c     = flow_scale_q;
			end
			abpf_pkg::ST_F_MXW: begin
				if (mul_sts.done) begin
					we        = 1'b1;
					wa        = abpf_pkg::A_LF;
					wd        = m_sat;
					mul_start = 1'b1;
					mul_d     = $signed(sy_w[abpf_pkg::MUL_D_W-1:0]);
					mul_c     = flow_scale_q;
				end
			end
			abpf_pkg::ST_F_MYW: begin
				if (mul_sts.done) begin
					we = 1'b1;
					wa = abpf_pkg::A_LF + 5'd1;
					wd = (dir_q == abpf_pkg::DIR_DOWN) ? m_sat : m_neg;
				end
			end
			abpf_pkg::ST_F_LZ: begin
				we = 1'b1;
				wa = abpf_pkg::A_LF + 5'd2;
				wd = {acc_q[2][31:0], 16'd0};
			end
			abpf_pkg::ST_F_RD0: begin
				re = 1'b1;
				ra = abpf_pkg::A_LF;
			end
			abpf_pkg::ST_F_RD1: begin
				re = 1'b1;
				ra = abpf_pkg::A_REF;
			end
			abpf_pkg::ST_F_A0: begin
				we = 1'b1;
				wa = abpf_pkg::A_REF;
				wd = add_rd_x;
				re = 1'b1;
				ra = abpf_pkg::A_LF + 5'd1;
			end
			abpf_pkg::ST_F_RD2: begin
				re = 1'b1;
				ra = abpf_pkg::A_REF + 5'd1;
			end
			abpf_pkg::ST_F_A1: begin
				we = 1'b1;
				wa = abpf_pkg::A_REF + 5'd1;
				wd = add_rd_x;
				re = 1'b1;
				ra = abpf_pkg::A_LF + 5'd2;
			end
			abpf_pkg::ST_F_H: begin
				re = 1'b1;
				ra = abpf_pkg::A_HPREV;
			end
			abpf_pkg::ST_H_RD: begin
				re = 1'b1;
				ra = abpf_pkg::A_REF + 5'd2;
			end
			abpf_pkg::ST_H_UPD: begin
				we = 1'b1;
				wa = abpf_pkg::A_REF + 5'd2;
				wd = ht_w;
			end
			abpf_pkg::ST_H_HP: begin
				we = 1'b1;
				wa = abpf_pkg::A_HPREV;
				wd = x_q;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abpf_pkg::ST_IDLE;
			ax_q        <= 2'd0;
			cur_mode_q  <= '0;
			prev_mode_q <= '0;
			last_az_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				abpf_pkg::ST_IDLE: begin
					if (in_acc) begin
						ax_q <= 2'd0;
						if (abpf_pkg::cmd_t'(samples.command) == abpf_pkg::CMD_MODE) begin
							cur_mode_q <= samples.mode_value;
						end
						if (abpf_pkg::cmd_t'(samples.command) == abpf_pkg::CMD_ACCEL) begin
							// Last vertical sample, clamped to 16 bits.
							if (samples.sample_z[31:15] == {17{samples.sample_z[31]}}) begin
								last_az_q <= samples.sample_z[15:0];
							end else if (samples.sample_z[31]) begin
								last_az_q <= 16'sh8000;
							end else begin
								last_az_q <= 16'sh7fff;
							end
						end
					end
				end
				abpf_pkg::ST_A_FPWAIT: begin
					if (mul_sts.done && ax_q != 2'd2) begin
						ax_q <= ax_q + 2'd1;
					end
				end
				abpf_pkg::ST_A_OUT: begin
					if (out_take) begin
						out_valid_q <= 1'b1;
					end
				end
				abpf_pkg::ST_H_HP: begin
					prev_mode_q <= cur_mode_q;
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			abpf_pkg::ST_IDLE: begin
				if (in_acc) begin
					acc_q[0] <= samples.sample_x;
					acc_q[1] <= samples.sample_y;
					acc_q[2] <= samples.sample_z;
					dir_q    <= samples.flow_direction;
				end
			end
			abpf_pkg::ST_A_IPMUL:  if (mul_sts.done) x_q <= add_rd_mul;
			abpf_pkg::ST_A_IPDIV:  y_q <= rd;
			abpf_pkg::ST_A_IPWAIT: if (div_sts.done) x_q <= add_x_div;
			abpf_pkg::ST_A_VO:     vo_q[ax_q] <= vo_w;
			abpf_pkg::ST_A_FPST:   x_q <= rd;
			abpf_pkg::ST_A_FPWAIT: if (mul_sts.done) fp_q[ax_q] <= add_x_mul;
			abpf_pkg::ST_A_OUT: begin
				if (out_take) begin
					out_px_q <= abpf_pkg::sat48(-abpf_pkg::wide_t'(fp_q[0]));
					out_py_q <= abpf_pkg::sat48(-abpf_pkg::wide_t'(fp_q[1]));
					out_pz_q <= fp_q[2];
					out_vx_q <= abpf_pkg::sat48(-abpf_pkg::wide_t'(vo_q[0]));
					out_vy_q <= abpf_pkg::sat48(-abpf_pkg::wide_t'(vo_q[1]));
					out_vz_q <= vo_q[2];
				end
			end
			abpf_pkg::ST_B_MUL:    x_q <= rd;
			abpf_pkg::ST_B_WAIT:   if (mul_sts.done) x_q <= add_x_mul;
			abpf_pkg::ST_F_RD1:    x_q <= rd;
			abpf_pkg::ST_F_RD2:    x_q <= rd;
			abpf_pkg::ST_F_H:      x_q <= rd;
			abpf_pkg::ST_H_RD:     y_q <= reseed ? x_q : rd;
			default: ;
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.pos_x = out_px_q;
	assign results.pos_y = out_py_q;
	assign results.pos_z = out_pz_q;
	assign results.vel_x = out_vx_q;
	assign results.vel_y = out_vy_q;
	assign results.vel_z = out_vz_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_sts.busy && div_sts.busy))
		else $error("multiplier and divider busy at the same time");

	a_result_from_accel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == abpf_pkg::ST_A_OUT))
		else $error("result beat raised outside the accel sequence");

	a_mode_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && samples.command == abpf_pkg::CMD_MODE) |=> state_q == abpf_pkg::ST_IDLE)
		else $error("mode change did not complete in one cycle");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		ax_q != 2'd3)
		else $error("axis counter out of range");

endmodule

// ----- sim/tb_accel_baro_flow_position_fusion_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_baro_flow_position_fusion_core
// Drives tagged accel, baro, flow and mode events into the fusion core under
// random source gaps and sink stalls. A bit-exact fusion predictor forecasts
// every result beat, and each beat is compared field by field. The run walks
// through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_accel_baro_flow_position_fusion_core;
	import abpf_pkg::*;

	// One input event as the block sees it.
	typedef struct {
		cmd_t               cmd;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [7:0]         dir;
		logic [7:0]         mode;
	} event_t;

	// One result beat: fused position and differenced velocity.
	typedef struct {
		pos_t px, py, pz, vx, vy, vz;
	} fusion_out_t;

	// ------------------------------------------------------------------------
	// Fusion predictor and store of expected beats.
	// ------------------------------------------------------------------------
	class fusion_scoreboard;
		localparam longint P_MAX = 64'sd140737488355327;
		localparam longint P_MIN = -64'sd140737488355328;

		longint coef [8];
		longint az_last;
		longint vel [3], ipos [3], ipos_prev [3], fused [3], refp [3], flow_last [3];
		longint baro_lp, height_prev;
		int unsigned mode_now, mode_prev;
		fusion_out_t pending [$];
		int errors;
		int beats_checked;

		function new();
			coef[REG_POS_XY_CORR]  = RST_POS_XY_CORR;
			coef[REG_POS_Z_CORR]   = RST_POS_Z_CORR;
			coef[REG_VEL_XY_INTEG] = RST_VEL_XY_INTEG;
			coef[REG_VEL_Z_INTEG]  = RST_VEL_Z_INTEG;
			coef[REG_BARO_FAST]    = RST_BARO_FAST;
			coef[REG_BARO_SLOW]    = RST_BARO_SLOW;
			coef[REG_AZ_LIMIT]     = RST_AZ_LIMIT;
			coef[REG_FLOW_SCALE]   = RST_FLOW_SCALE;
			az_last = 0;
			for (int i = 0; i < 3; i++) begin
				vel[i] = 0; ipos[i] = 0; ipos_prev[i] = 0;
				fused[i] = 0; refp[i] = 0; flow_last[i] = 0;
			end
			baro_lp = 0;
			height_prev = 0;
			mode_now = 0;
			mode_prev = 0;
			errors = 0;
			beats_checked = 0;
		endfunction

		function void set_reg(reg_idx_t idx, longint value);
			coef[idx] = (idx == REG_AZ_LIMIT) ? (value & 'h7FFF) : (value & 'hFFFFFF);
		endfunction

		function longint clamp48(longint v);
			if (v > P_MAX) return P_MAX;
			if (v < P_MIN) return P_MIN;
			return v;
		endfunction

		// Q0.24 product, rounded to nearest with ties upward.
		function longint scale_q24(longint d, longint c);
			longint hi, lo;
			hi = d >>> 24;
			lo = d - hi * 16777216;
			return hi * c + ((lo * c + 8388608) >>> 24);
		endfunction

		// Division by the sample rate, rounded to nearest with ties upward.
		function longint per_sample(longint n);
			longint q;
			q = n + HALF_FREQ;
			if (q >= 0) return q / ACCEL_FREQ;
			return -((-q + ACCEL_FREQ - 1) / ACCEL_FREQ);
		endfunction

		function void move_height(longint h);
			refp[2] = clamp48(refp[2] + (h - height_prev));
			height_prev = h;
			mode_prev = mode_now;
		endfunction

		// Called for every accepted input beat.
		function void note_event(event_t e);
			longint sx, sy, sz, mag, a, fx, fy, ac [3], vo [3], integ, corr;
			fusion_out_t r;
			sx = e.x; sy = e.y; sz = e.z;
			case (e.cmd)
				CMD_MODE: mode_now = e.mode;
				CMD_BARO: begin
					mag = (az_last < 0) ? -az_last : az_last;
					a = (mag > coef[REG_AZ_LIMIT]) ? coef[REG_BARO_FAST] : coef[REG_BARO_SLOW];
					baro_lp = clamp48(baro_lp + scale_q24(sx - baro_lp, a));
					if (mode_now >= 1) begin
						if (mode_prev < 1) height_prev = baro_lp;
						move_height(baro_lp);
					end
				end
				CMD_FLOW: begin
					if (e.dir == DIR_DOWN || e.dir == DIR_UP) begin
						fx = clamp48((sx * coef[REG_FLOW_SCALE] + 128) >>> 8);
						fy = clamp48((sy * coef[REG_FLOW_SCALE] + 128) >>> 8);
						flow_last[0] = fx;
						if (e.dir == DIR_DOWN) begin
							flow_last[1] = fy;
							flow_last[2] = sz * 65536;
						end else begin
							flow_last[1] = clamp48(-fy);
						end
					end
					refp[0] = clamp48(refp[0] + flow_last[0]);
					refp[1] = clamp48(refp[1] + flow_last[1]);
					if (mode_now == MODE_FLOW_HEIGHT && e.dir == DIR_DOWN) begin
						if (mode_prev != 0) height_prev = flow_last[2];
						move_height(flow_last[2]);
					end
				end
				default: begin
					ac[0] = sx; ac[1] = sy; ac[2] = sz;
					az_last = (sz > 32767) ? 32767 : ((sz < -32768) ? -32768 : sz);
					for (int i = 0; i < 3; i++) begin
						integ = (i < 2) ? coef[REG_VEL_XY_INTEG] : coef[REG_VEL_Z_INTEG];
						corr = (i < 2) ? coef[REG_POS_XY_CORR] : coef[REG_POS_Z_CORR];
						vel[i] = clamp48(vel[i] + per_sample(ac[i] * 65536));
						ipos[i] = clamp48(ipos[i] + scale_q24(vel[i], integ));
						ipos[i] = clamp48(ipos[i] + per_sample(refp[i] - ipos[i]));
						vo[i] = clamp48((ipos[i] - ipos_prev[i]) * ACCEL_FREQ);
						ipos_prev[i] = ipos[i];
						fused[i] = clamp48(fused[i] + scale_q24(refp[i] - fused[i], corr));
					end
					r.px = pos_t'(clamp48(-fused[0]));
					r.py = pos_t'(clamp48(-fused[1]));
					r.pz = pos_t'(fused[2]);
					r.vx = pos_t'(clamp48(-vo[0]));
					r.vy = pos_t'(clamp48(-vo[1]));
					r.vz = pos_t'(vo[2]);
					pending.push_back(r);
				end
			endcase
		endfunction

		task report(string what, pos_t got, pos_t want);
			errors++;
			$display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
		endtask

		// Called for every accepted result beat.
		task check_beat(fusion_out_t got);
			fusion_out_t want;
			beats_checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("[%0t] MISMATCH unexpected result beat", $time);
				return;
			end
			want = pending.pop_front();
			if (got.px !== want.px) report("pos_x", got.px, want.px);
			if (got.py !== want.py) report("pos_y", got.py, want.py);
			if (got.pz !== want.pz) report("pos_z", got.pz, want.pz);
			if (got.vx !== want.vx) report("vel_x", got.vx, want.vx);
			if (got.vy !== want.vy) report("vel_y", got.vy, want.vy);
			if (got.vz !== want.vz) report("vel_z", got.vz, want.vz);
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the device.
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	abpf_in_if  samples();
	abpf_out_if results();

	accel_baro_flow_position_fusion_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	fusion_scoreboard fusion_sb = new();

	// When set, neither side inserts gaps or stalls.
	bit no_idle;
	int events_sent;
	int accel_sent;
	longint cycle_count;

	localparam longint CYCLE_LIMIT = 2000000;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d beats still expected",
				cycle_count, fusion_sb.pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result beats are sampled at the rising edge.
	always @(posedge clk) begin
		fusion_out_t got;
		if (arst_n && results.valid && results.ready) begin
			got.px = results.pos_x; got.py = results.pos_y; got.pz = results.pos_z;
			got.vx = results.vel_x; got.vy = results.vel_y; got.vz = results.vel_z;
			fusion_sb.check_beat(got);
		end
	end

	// The sink stalls a random number of cycles before each beat it takes.
	initial begin
		int stall;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			repeat (stall) begin
				@(negedge clk);
				results.ready = 1'b0;
			end
			@(negedge clk);
			results.ready = 1'b1;
			do @(posedge clk); while (!results.valid);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers.
	// ------------------------------------------------------------------------

	// Sends one event beat; valid stays high if the next call has no gap.
	task send_event(event_t e);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			samples.valid = 1'b0;
		end
		@(negedge clk);
		samples.valid          = 1'b1;
		samples.command        = e.cmd;
		samples.sample_x       = e.x;
		samples.sample_y       = e.y;
		samples.sample_z       = e.z;
		samples.flow_direction = e.dir;
		samples.mode_value     = e.mode;
		do @(posedge clk); while (!samples.ready);
		fusion_sb.note_event(e);
		events_sent++;
		if (e.cmd == CMD_ACCEL) accel_sent++;
	endtask

	task stop_events();
		@(negedge clk);
		samples.valid = 1'b0;
	endtask

	// An APB write: a setup cycle, then an access cycle.
	task write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = PADDR_W'(idx) << 2;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		fusion_sb.set_reg(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Waits until all results are in and any trailing baro or flow work is over.
	task wait_drained();
		while (fusion_sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Register settings: mode 0 typical, 1 all ones, 2 all zeros, 3 random.
	task program_regs(int setting);
		logic [31:0] v;
		for (int i = 0; i < 8; i++) begin
			case (setting)
				0: v = (i == REG_AZ_LIMIT) ? 32'd300 : 32'd900000 + 32'(i) * 32'd70000;
				1: v = (i == REG_AZ_LIMIT) ? 32'h7FFF : 32'hFFFFFF;
				2: v = 32'd0;
				default: v = $urandom;
			endcase
			write_reg(reg_idx_t'(i), v);
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus content.
	// ------------------------------------------------------------------------

	// Mostly modest values, sometimes full range or an extreme.
	function logic signed [31:0] pick_sample(int small_span);
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return 32'sh7FFFFFFF;
			2: return 32'sh80000000;
			default: return $urandom_range(0, 2 * small_span) - small_span;
		endcase
	endfunction

	function event_t random_event();
		event_t e;
		int pick;
		e.x = pick_sample(3000);
		e.y = pick_sample(3000);
		e.z = pick_sample(1000);
		e.dir = $urandom;
		e.mode = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			e.cmd = CMD_ACCEL;
		end else if (pick < 63) begin
			e.cmd = CMD_BARO;
			// Baro altitude in Q15.16, occasionally raw full range.
			if ($urandom_range(0, 3) != 0) e.x = 32'($urandom_range(0, 400)) << 16;
		end else if (pick < 90) begin
			e.cmd = CMD_FLOW;
			// Downward and upward sensors are the common case.
			if ($urandom_range(0, 4) != 0) e.dir = 8'($urandom_range(0, 1));
		end else begin
			e.cmd = CMD_MODE;
			if ($urandom_range(0, 2) != 0) e.mode = 8'($urandom_range(0, 1));
		end
		return e;
	endfunction

	function event_t make_event(cmd_t c, int x, int y, int z, logic [7:0] d, logic [7:0] m);
		event_t e;
		e.cmd = c; e.x = x; e.y = y; e.z = z; e.dir = d; e.mode = m;
		return e;
	endfunction

	// Directed opening: extremes, every command, re-seeds on mode switches,
	// upward and unknown flow orientations, and accel z beyond 16 bits.
	task directed_events();
		send_event(make_event(CMD_ACCEL, 0, 0, 0, 0, 0));
		send_event(make_event(CMD_FLOW, 120, -80, 3, DIR_DOWN, 0));
		send_event(make_event(CMD_ACCEL, 100, -100, 20000, 0, 0));
		send_event(make_event(CMD_BARO, 32'sh00640000, 0, 0, 0, 0));
		send_event(make_event(CMD_ACCEL, 5, 5, 100, 0, 0));
		send_event(make_event(CMD_BARO, 32'sh00320000, 0, 0, 0, 0));
		send_event(make_event(CMD_MODE, 0, 0, 0, 0, 1));
		send_event(make_event(CMD_BARO, 32'sh00700000, 0, 0, 0, 0));
		send_event(make_event(CMD_BARO, 32'sh00710000, 0, 0, 0, 0));
		send_event(make_event(CMD_FLOW, -50, 60, 9, DIR_UP, 0));
		send_event(make_event(CMD_FLOW, 1, 1, 1, 8'd7, 0));
		send_event(make_event(CMD_ACCEL, 0, 0, -70000, 0, 0));
		send_event(make_event(CMD_MODE, 0, 0, 0, 0, 8'd255));
		send_event(make_event(CMD_MODE, 0, 0, 0, 0, MODE_FLOW_HEIGHT));
		send_event(make_event(CMD_FLOW, 10, 10, 5, DIR_DOWN, 0));
		send_event(make_event(CMD_FLOW, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			DIR_DOWN, 0));
		send_event(make_event(CMD_FLOW, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			8'hFF, 0));
		send_event(make_event(CMD_BARO, 32'sh7FFFFFFF, 0, 0, 0, 0));
		send_event(make_event(CMD_BARO, 32'sh80000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
		for (int i = 0; i < 3; i++) begin
			send_event(make_event(CMD_ACCEL, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
				8'hFF, 8'hFF));
		end
		send_event(make_event(CMD_ACCEL, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0));
		stop_events();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		samples.valid          = 1'b0;
		samples.command        = CMD_ACCEL;
		samples.sample_x       = '0;
		samples.sample_y       = '0;
		samples.sample_z       = '0;
		samples.flow_direction = '0;
		samples.mode_value     = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		no_idle = 1'b0;
		events_sent = 0;
		accel_sent = 0;
		cycle_count = 0;

		// Reset is applied once.
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The first phase runs on the reset defaults.
		directed_events();
		wait_drained();

		// Each phase after the first picks a register setting; every phase sends random
		// events, with stretches in which neither side idles.
		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				wait_drained();
				program_regs(phase - 1);
			end
			for (int n = 0; n < 265; n++) begin
				if (n % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
				send_event(random_event());
			end
			no_idle = 1'b0;
			stop_events();
		end

		// Drain, with the watchdog as the bound, then allow the tail latency.
		while (fusion_sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d events (%0d accel samples) over five register settings;",
			events_sent, accel_sent);
		$display("checked %0d result beats field by field.", fusion_sb.beats_checked);
		if (fusion_sb.errors == 0 && fusion_sb.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
